// ----- sv/ovflp_pkg.sv -----
// Shared types, character codes and constant tables for the OBJ line parser.
package ovflp_pkg;

  localparam int FRACTION_BITS_DEF   = 16;
  localparam int MANTISSA_DIGITS_DEF = 9;
  localparam int INT_DIGIT_LIMIT_DEF = 31;
  localparam int CMD_DEPTH           = 4;

  localparam int SC_W  = 11;   // decimal scale, -510..510
  localparam int CNT_W = 5;    // digit counter
  localparam int KMAX  = 40;   // largest divide-down power of ten
  localparam int KI_W  = $clog2(KMAX + 1);
  localparam int DIV_W = 90;   // covers the widest dividend plus one

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_EU    = 8'h45;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_V     = 8'h76;

  typedef enum logic [2:0] {
    PH_LINE, PH_DISCARD, PH_GAP, PH_INT, PH_FRAC, PH_ESTART, PH_EDIG, PH_TAIL
  } ph_t;

  typedef enum logic [1:0] {KIND_NONE, KIND_V, KIND_F} kind_t;

  typedef enum logic [1:0] {
    ELEM_VERTEX = 2'd0,
    ELEM_FACE   = 2'd1,
    ELEM_STOP   = 2'd2
  } elem_t;

  typedef enum logic [1:0] {BS_IDLE, BS_MUL, BS_DIV, BS_EMIT} bst_t;

  // parse state of the front, mantissa kept apart (its width is a parameter)
  typedef struct packed {
    ph_t              phase;
    kind_t            kind;
    logic [1:0]       fnum;
    logic             neg;
    logic [CNT_W-1:0] dcnt;
    logic [7:0]       fcnt;
    logic [7:0]       drop;
    logic             eneg;
    logic [7:0]       evl;
  } pst_t;

  // request from front to back
  typedef struct packed {
    logic                   fld_vld;
    logic [1:0]             fld_idx;
    logic                   is_vtx;
    logic                   neg;
    logic signed [SC_W-1:0] scale;
    logic                   emit_vld;
    elem_t                  emit_kind;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

  typedef logic [DIV_W-1:0] pow_tab_t [KMAX+1];

  function automatic pow_tab_t pow10_table();
    pow_tab_t         t;
    logic [DIV_W+3:0] v;
    v = (DIV_W+4)'(1);
    for (int k = 0; k <= KMAX; k++) begin
      t[k] = v[DIV_W-1:0];
      v = (v << 3) + (v << 1);
      if (|v[DIV_W+3:DIV_W]) v = {4'b0000, {DIV_W{1'b1}}};
    end
    return t;
  endfunction

  localparam pow_tab_t POW10 = pow10_table();

  function automatic int mant_width(int digits);
    longint unsigned v;
    int              w;
    v = 64'd1;
    for (int i = 0; i < digits; i++) v = v * 64'd10;
    w = $clog2(v);
    return (w > 32) ? w : 32;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [7:0] sat_inc8(logic [7:0] v);
    return (v != 8'hFF) ? v + 8'd1 : v;
  endfunction

endpackage

// ----- sv/ovflp_cmd_fifo.sv -----
// Small request queue between the character front and the conversion back.
module ovflp_cmd_fifo import ovflp_pkg::*; #(
  parameter int WIDTH = CMD_W,
  parameter int DEPTH = CMD_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (!do_push && do_pop) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ----- sv/ovflp_front.sv -----
// Character front: classifies lines and accumulates digits, one byte per cycle while the request queue has room.
module ovflp_front import ovflp_pkg::*; #(
  parameter int MANT_W          = 32,
  parameter int MANTISSA_DIGITS = MANTISSA_DIGITS_DEF,
  parameter int INT_DIGIT_LIMIT = INT_DIGIT_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic [7:0]        in_char_code,
  output logic              in_full,
  output logic              cmd_push,
  output cmd_t              cmd_o,
  output logic [MANT_W-1:0] cmd_mant,
  input  logic              cmd_full
);

  localparam logic [MANT_W+3:0] FACE_SAT = (MANT_W+4)'(64'h80000000);

  pst_t              st_r, st_nxt;
  logic [MANT_W-1:0] mant_r, mant_nxt;
  logic              acc;

  assign in_full  = cmd_full;
  assign acc      = in_push && !cmd_full;
  assign cmd_mant = mant_r;

  function automatic pst_t clr(pst_t s);
    pst_t r;
    r      = s;
    r.neg  = 1'b0;
    r.dcnt = '0;
    r.fcnt = '0;
    r.drop = '0;
    r.eneg = 1'b0;
    r.evl  = '0;
    return r;
  endfunction

  function automatic cmd_t field_cmd(pst_t s);
    cmd_t                   r;
    logic signed [SC_W-1:0] ex;
    ex = $signed({{(SC_W-8){1'b0}}, s.evl});
    if (s.eneg) ex = -ex;
    r           = '0;
    r.fld_vld   = 1'b1;
    r.fld_idx   = s.fnum;
    r.is_vtx    = (s.kind == KIND_V);
    r.neg       = s.neg;
    r.scale     = ex + $signed({{(SC_W-8){1'b0}}, s.drop})
                     - $signed({{(SC_W-8){1'b0}}, s.fcnt});
    r.emit_kind = ELEM_STOP;
    return r;
  endfunction

  function automatic logic take_fn(input pst_t s, input logic [MANT_W-1:0] m,
                                   input logic [7:0] c, output pst_t so,
                                   output logic [MANT_W-1:0] mo);
    logic              dig, sgn, ex, ok, mz;
    logic [3:0]        d;
    logic [MANT_W+3:0] mx, t;
    logic [11:0]       te;
    dig = (c >= CH_ZERO) && (c <= CH_NINE);
    sgn = (c == CH_PLUS) || (c == CH_MINUS);
    ex  = (c == CH_E) || (c == CH_EU);
    d   = dig ? 4'(c - CH_ZERO) : 4'd0;
    mx  = {4'b0000, m};
    t   = (mx << 3) + (mx << 1) + (MANT_W+4)'(d);
    te  = ({4'b0000, s.evl} << 3) + ({4'b0000, s.evl} << 1) + 12'(d);
    mz  = (m == '0) && (d == 4'd0);
    so  = s;
    mo  = m;
    ok  = 1'b0;
    if (s.phase == PH_GAP && is_blank(c)) begin
      ok = 1'b1;
    end else if (s.phase == PH_GAP && sgn) begin
      so.neg   = (c == CH_MINUS);
      so.phase = PH_INT;
      ok       = 1'b1;
    end else if (s.kind == KIND_F) begin
      if (dig && s.dcnt < CNT_W'(INT_DIGIT_LIMIT)) begin
        mo       = (t > FACE_SAT) ? FACE_SAT[MANT_W-1:0] : t[MANT_W-1:0];
        so.dcnt  = s.dcnt + 1'b1;
        so.phase = PH_INT;
        ok       = 1'b1;
      end
    end else if (s.phase == PH_GAP || s.phase == PH_INT || s.phase == PH_FRAC) begin
      if (dig) begin
        ok = 1'b1;
        if (s.phase == PH_FRAC) begin
          if (mz) begin
            so.fcnt = sat_inc8(s.fcnt);
          end else if (s.dcnt < CNT_W'(MANTISSA_DIGITS)) begin
            mo      = t[MANT_W-1:0];
            so.dcnt = s.dcnt + 1'b1;
            so.fcnt = sat_inc8(s.fcnt);
          end
        end else begin
          so.phase = PH_INT;
          if (!mz) begin
            if (s.dcnt < CNT_W'(MANTISSA_DIGITS)) begin
              mo      = t[MANT_W-1:0];
              so.dcnt = s.dcnt + 1'b1;
            end else begin
              so.drop = sat_inc8(s.drop);
            end
          end
        end
      end else if (c == CH_DOT && s.phase != PH_FRAC) begin
        so.phase = PH_FRAC;
        ok       = 1'b1;
      end else if (ex) begin
        so.phase = PH_ESTART;
        ok       = 1'b1;
      end
    end else if (s.phase == PH_ESTART && sgn) begin
      so.eneg  = (c == CH_MINUS);
      so.phase = PH_EDIG;
      ok       = 1'b1;
    end else if ((s.phase == PH_ESTART || s.phase == PH_EDIG) && dig) begin
      so.evl   = (te > 12'd255) ? 8'hFF : te[7:0];
      so.phase = PH_EDIG;
      ok       = 1'b1;
    end
    return ok;
  endfunction

  // all-zero state is line start with no line kind
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= '0;
      mant_r <= '0;
    end else begin
      st_r   <= st_nxt;
      mant_r <= mant_nxt;
    end
  end

  always_comb begin
    pst_t              s0, s1, s2;
    logic [MANT_W-1:0] m0, m1, m2;
    logic              ok1, ok2, nl;
    st_nxt   = st_r;
    mant_nxt = mant_r;
    cmd_push = 1'b0;
    cmd_o    = '0;
    cmd_o.emit_kind = ELEM_STOP;
    s0  = st_r;
    s2  = st_r;
    m0  = mant_r;
    m2  = mant_r;
    ok2 = 1'b0;
    nl  = (in_char_code == CH_NL) || (in_char_code == CH_NUL);
    ok1 = take_fn(st_r, mant_r, in_char_code, s1, m1);
    if (acc) begin
      unique case (st_r.phase)
        PH_LINE: begin
          if (!is_blank(in_char_code)) begin
            if (in_char_code == CH_V || in_char_code == CH_F) begin
              st_nxt       = clr(st_r);
              st_nxt.kind  = (in_char_code == CH_V) ? KIND_V : KIND_F;
              st_nxt.fnum  = 2'd0;
              st_nxt.phase = PH_GAP;
              mant_nxt     = '0;
            end else begin
              st_nxt.kind = KIND_NONE;
              if (in_char_code != CH_NUL) st_nxt.phase = PH_DISCARD;
              cmd_push        = 1'b1;
              cmd_o.emit_vld  = 1'b1;
              cmd_o.emit_kind = ELEM_STOP;
            end
          end
        end
        PH_DISCARD: begin
          if (nl) st_nxt.phase = PH_LINE;
        end
        default: begin
          if (nl) begin
            // line end: flush the open field and emit the element
            cmd_push        = 1'b1;
            cmd_o           = field_cmd(st_r);
            cmd_o.fld_vld   = (st_r.phase != PH_TAIL);
            cmd_o.emit_vld  = 1'b1;
            cmd_o.emit_kind = (st_r.kind == KIND_V) ? ELEM_VERTEX : ELEM_FACE;
            st_nxt.phase    = PH_LINE;
          end else if (st_r.phase != PH_TAIL) begin
            if (st_r.phase != PH_GAP && ok1) begin
              st_nxt   = s1;
              mant_nxt = m1;
            end else begin
              if (st_r.phase != PH_GAP) begin
                cmd_push = 1'b1;
                cmd_o    = field_cmd(st_r);
                s0       = clr(st_r);
                m0       = '0;
                s0.fnum  = st_r.fnum + 2'd1;
                s0.phase = (st_r.fnum == 2'd2) ? PH_TAIL : PH_GAP;
              end
              if (s0.phase == PH_GAP) begin
                ok2 = take_fn(s0, m0, in_char_code, s2, m2);
                if (ok2) begin
                  st_nxt   = s2;
                  mant_nxt = m2;
                end else begin
                  // byte cannot open a field: rest of the line is ignored
                  st_nxt       = s0;
                  st_nxt.phase = PH_TAIL;
                  mant_nxt     = m0;
                end
              end else begin
                st_nxt   = s0;
                mant_nxt = m0;
              end
            end
          end
        end
      endcase
    end
  end

endmodule

// ----- sv/ovflp_back.sv -----
// Conversion back: turns field requests into Q-format or integer results, emits elements.
module ovflp_back import ovflp_pkg::*; #(
  parameter int MANT_W        = 32,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_vld,
  input  cmd_t               cmd,
  input  logic [MANT_W-1:0]  cmd_mant,
  output logic               cmd_pop,
  input  logic [23:0]        color,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [1:0]         out_element_kind,
  output logic signed [31:0] out_coord_x,
  output logic signed [31:0] out_coord_y,
  output logic signed [31:0] out_coord_z,
  output logic signed [31:0] out_index_first,
  output logic signed [31:0] out_index_second,
  output logic signed [31:0] out_index_third,
  output logic [23:0]        out_vertex_color
);

  localparam int XW = MANT_W + FRACTION_BITS + 1;
  localparam int BW = $clog2(XW);
  localparam logic [XW-1:0] LIM_P = XW'(64'h7FFFFFFF);
  localparam logic [XW-1:0] LIM_N = XW'(64'h80000000);

  bst_t          bst_r, bst_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [XW-1:0] acc_r, acc_nxt;
  logic [SC_W-1:0] cnt_r, cnt_nxt;
  logic [XW-1:0] rem_r, rem_nxt;
  logic [XW:0]   d_r, d_nxt;
  logic [XW-1:0] q_r, q_nxt;
  logic [BW-1:0] bit_r, bit_nxt;
  logic [31:0]   res_r [3];
  logic [31:0]   res_nxt [3];

  logic          ovld_r, ovld_nxt;
  elem_t         okind_r, okind_nxt;
  logic [31:0]   ox_r, oy_r, oz_r, oi1_r, oi2_r, oi3_r;
  logic [31:0]   ox_nxt, oy_nxt, oz_nxt, oi1_nxt, oi2_nxt, oi3_nxt;
  logic [23:0]   ocol_r, ocol_nxt;

  function automatic logic [31:0] to_int(logic neg, logic [MANT_W-1:0] m);
    if (neg) return (m >= MANT_W'(64'h80000000)) ? 32'h80000000 : 32'd0 - m[31:0];
    return (m > MANT_W'(64'h7FFFFFFF)) ? 32'h7FFFFFFF : m[31:0];
  endfunction

  assign out_empty        = !ovld_r;
  assign out_element_kind = okind_r;
  assign out_coord_x      = ox_r;
  assign out_coord_y      = oy_r;
  assign out_coord_z      = oz_r;
  assign out_index_first  = oi1_r;
  assign out_index_second = oi2_r;
  assign out_index_third  = oi3_r;
  assign out_vertex_color = ocol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bst_r    <= BS_IDLE;
      ovld_r   <= 1'b0;
      res_r[0] <= '0;
      res_r[1] <= '0;
      res_r[2] <= '0;
    end else begin
      bst_r  <= bst_nxt;
      ovld_r <= ovld_nxt;
      res_r  <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    acc_r   <= acc_nxt;
    cnt_r   <= cnt_nxt;
    rem_r   <= rem_nxt;
    d_r     <= d_nxt;
    q_r     <= q_nxt;
    bit_r   <= bit_nxt;
    okind_r <= okind_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    oz_r    <= oz_nxt;
    oi1_r   <= oi1_nxt;
    oi2_r   <= oi2_nxt;
    oi3_r   <= oi3_nxt;
    ocol_r  <= ocol_nxt;
  end

  always_comb begin
    logic            wr_en, done;
    logic [1:0]      wr_idx;
    logic [31:0]     wr_val, mag;
    logic [XW-1:0]   lim, acc_sh, q_new, qq;
    logic [XW:0]     r2, diff;
    logic            ge;
    logic [SC_W-1:0] nscale;
    logic [KI_W-1:0] kidx;
    logic [DIV_W-1:0] pw;
    bst_nxt   = bst_r;
    cmd_nxt   = cmd_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    d_nxt     = d_r;
    q_nxt     = q_r;
    bit_nxt   = bit_r;
    res_nxt   = res_r;
    ovld_nxt  = ovld_r && !out_pop;
    okind_nxt = okind_r;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    oz_nxt    = oz_r;
    oi1_nxt   = oi1_r;
    oi2_nxt   = oi2_r;
    oi3_nxt   = oi3_r;
    ocol_nxt  = ocol_r;
    cmd_pop   = 1'b0;
    wr_en     = 1'b0;
    done      = 1'b0;
    wr_idx    = cmd_r.fld_idx;
    wr_val    = '0;
    mag       = '0;
    lim       = cmd_r.neg ? LIM_N : LIM_P;
    acc_sh    = acc_r << FRACTION_BITS;
    r2        = {rem_r, acc_r[XW-1]};
    diff      = r2 - d_r;
    ge        = (r2 >= d_r);
    q_new     = {q_r[XW-2:0], ge};
    qq        = (q_new >> 1) + XW'(q_new[0]);
    nscale    = -cmd.scale;
    kidx      = (nscale > SC_W'(KMAX)) ? KI_W'(KMAX) : nscale[KI_W-1:0];
    pw        = POW10[kidx];

    unique case (bst_r)
      BS_IDLE: begin
        if (cmd_vld) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
          if (cmd.fld_vld && cmd.is_vtx && (cmd_mant != '0)) begin
            if (!cmd.scale[SC_W-1]) begin
              acc_nxt = XW'(cmd_mant);
              cnt_nxt = cmd.scale;
              bst_nxt = BS_MUL;
            end else if (|pw[DIV_W-1:XW+1]) begin
              // divisor exceeds any dividend: quotient is zero
              wr_en   = 1'b1;
              wr_idx  = cmd.fld_idx;
              wr_val  = '0;
              bst_nxt = cmd.emit_vld ? BS_EMIT : BS_IDLE;
            end else begin
              d_nxt   = pw[XW:0];
              rem_nxt = '0;
              q_nxt   = '0;
              acc_nxt = {cmd_mant, {(FRACTION_BITS+1){1'b0}}};
              bit_nxt = BW'(XW - 1);
              bst_nxt = BS_DIV;
            end
          end else begin
            if (cmd.fld_vld) begin
              wr_en  = 1'b1;
              wr_idx = cmd.fld_idx;
              wr_val = cmd.is_vtx ? 32'd0 : to_int(cmd.neg, cmd_mant);
            end
            bst_nxt = cmd.emit_vld ? BS_EMIT : BS_IDLE;
          end
        end
      end
      BS_MUL: begin
        if (cnt_r == '0) begin
          mag  = (acc_r > (lim >> FRACTION_BITS)) ? lim[31:0] : acc_sh[31:0];
          done = 1'b1;
        end else if (acc_r > lim) begin
          mag  = lim[31:0];
          done = 1'b1;
        end else begin
          acc_nxt = (acc_r << 3) + (acc_r << 1);
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      BS_DIV: begin
        // restoring divide by a power of ten, one quotient bit a cycle
        rem_nxt = ge ? diff[XW-1:0] : r2[XW-1:0];
        q_nxt   = q_new;
        acc_nxt = acc_r << 1;
        bit_nxt = bit_r - 1'b1;
        if (bit_r == '0) begin
          mag  = (qq > lim) ? lim[31:0] : qq[31:0];
          done = 1'b1;
        end
      end
      BS_EMIT: begin
        if (!ovld_r || out_pop) begin
          ovld_nxt  = 1'b1;
          okind_nxt = cmd_r.emit_kind;
          ox_nxt    = '0;
          oy_nxt    = '0;
          oz_nxt    = '0;
          oi1_nxt   = '0;
          oi2_nxt   = '0;
          oi3_nxt   = '0;
          ocol_nxt  = '0;
          if (cmd_r.emit_kind == ELEM_VERTEX) begin
            ox_nxt   = res_r[0];
            oy_nxt   = res_r[1];
            oz_nxt   = res_r[2];
            ocol_nxt = color;
          end else if (cmd_r.emit_kind == ELEM_FACE) begin
            oi1_nxt = res_r[0];
            oi2_nxt = res_r[1];
            oi3_nxt = res_r[2];
          end
          res_nxt[0] = '0;
          res_nxt[1] = '0;
          res_nxt[2] = '0;
          bst_nxt    = BS_IDLE;
        end
      end
      default: bst_nxt = BS_IDLE;
    endcase

    if (done) begin
      wr_en   = 1'b1;
      wr_val  = cmd_r.neg ? 32'd0 - mag : mag;
      bst_nxt = cmd_r.emit_vld ? BS_EMIT : BS_IDLE;
    end
    if (wr_en) res_nxt[wr_idx] = wr_val;
  end

endmodule

// ----- sv/obj_vertex_face_line_parser.sv -----
// Top level of the OBJ vertex/face line parser: front, request queue, back, color register.
//
//  channel | ports                                   | request taken when
//  --------+-----------------------------------------+-------------------------
//  input   | in_push, in_full, in_char_code          | in_push && !in_full
//  result  | out_empty, out_pop, out_* fields        | out_pop && !out_empty
//  config  | cfg_valid, cfg_ready, cfg_default_color | cfg_valid && cfg_ready
//
// The front takes one character a cycle while the request queue has room. The back
// converts face fields directly, scales vertex fields with a positive decimal scale
// by multiplying by ten, and divides those with a negative scale in its restoring
// divider over MANT_W+FRACTION_BITS+1 dividend bits (49 by default). in_full rises
// when the four-entry request queue fills. Reset needs no clearing pass.
module obj_vertex_face_line_parser import ovflp_pkg::*; #(
  parameter int FRACTION_BITS   = FRACTION_BITS_DEF,
  parameter int MANTISSA_DIGITS = MANTISSA_DIGITS_DEF,
  parameter int INT_DIGIT_LIMIT = INT_DIGIT_LIMIT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_char_code,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [1:0]         out_element_kind,
  output logic signed [31:0] out_coord_x,
  output logic signed [31:0] out_coord_y,
  output logic signed [31:0] out_coord_z,
  output logic signed [31:0] out_index_first,
  output logic signed [31:0] out_index_second,
  output logic signed [31:0] out_index_third,
  output logic [23:0]        out_vertex_color,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [23:0]        cfg_default_color
);

  localparam int MANT_W = mant_width(MANTISSA_DIGITS);
  localparam int FW     = CMD_W + MANT_W;

  logic              f_push, q_full, q_empty, q_pop;
  cmd_t              f_cmd, q_cmd;
  logic [MANT_W-1:0] f_mant, q_mant;
  logic [FW-1:0]     q_dout;
  logic [23:0]       color_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) color_r <= 24'hFFFFFF;
    else if (cfg_valid) color_r <= cfg_default_color;
  end

  ovflp_front #(
    .MANT_W          (MANT_W),
    .MANTISSA_DIGITS (MANTISSA_DIGITS),
    .INT_DIGIT_LIMIT (INT_DIGIT_LIMIT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_char_code (in_char_code),
    .in_full      (in_full),
    .cmd_push     (f_push),
    .cmd_o        (f_cmd),
    .cmd_mant     (f_mant),
    .cmd_full     (q_full)
  );

  ovflp_cmd_fifo #(
    .WIDTH (FW),
    .DEPTH (CMD_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   ({f_cmd, f_mant}),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign q_cmd  = q_dout[FW-1:MANT_W];
  assign q_mant = q_dout[MANT_W-1:0];

  ovflp_back #(
    .MANT_W        (MANT_W),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_vld          (!q_empty),
    .cmd              (q_cmd),
    .cmd_mant         (q_mant),
    .cmd_pop          (q_pop),
    .color            (color_r),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_element_kind (out_element_kind),
    .out_coord_x      (out_coord_x),
    .out_coord_y      (out_coord_y),
    .out_coord_z      (out_coord_z),
    .out_index_first  (out_index_first),
    .out_index_second (out_index_second),
    .out_index_third  (out_index_third),
    .out_vertex_color (out_vertex_color)
  );

endmodule

// ----- dv/obj_vertex_face_line_parser_test.sv -----
// Self-checking testbench for the OBJ vertex/face line parser: random text, queue-style handshakes.
module obj_vertex_face_line_parser_test;
  import ovflp_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int DRAIN_WAIT  = 300;
  localparam int CHARS_PER_PHASE = 410;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] cx, cy, cz, i1, i2, i3;
    logic [23:0] color;
  } element_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic [7:0] in_char_code = 8'h00;
  logic out_pop = 1'b0;
  logic cfg_valid = 1'b0;
  logic [23:0] cfg_default_color = 24'h000000;
  logic in_full, out_empty, cfg_ready;
  logic [1:0] out_element_kind;
  logic signed [31:0] out_coord_x, out_coord_y, out_coord_z;
  logic signed [31:0] out_index_first, out_index_second, out_index_third;
  logic [23:0] out_vertex_color;

  obj_vertex_face_line_parser u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [7:0] char_queue[$];
  element_t   element_queue[$];
  int fails = 0;
  int cycles = 0;
  int push_gap = 0;
  int pop_gap = 0;
  bit no_idle = 1'b0;

  // parser model state
  ph_t         m_phase;
  kind_t       m_kind;
  int          m_field;
  bit          m_neg, m_eneg;
  logic [63:0] m_mant;
  int          m_dcnt, m_fcnt, m_drop, m_exp;
  logic [31:0] m_res[3];
  logic [23:0] m_color;

  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic bit blank_char(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic int sat255(int v);
    return v < 255 ? v + 1 : v;
  endfunction

  function automatic void clear_number();
    m_neg = 0; m_mant = 0; m_dcnt = 0; m_fcnt = 0; m_drop = 0; m_eneg = 0; m_exp = 0;
  endfunction

  function automatic logic [31:0] face_value();
    if (m_neg) return (m_mant >= 64'h8000_0000) ? 32'h8000_0000 : -m_mant[31:0];
    return (m_mant > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m_mant[31:0];
  endfunction

  function automatic logic [31:0] fixed_value();
    logic [63:0]  lim, m, mag, q64;
    logic [191:0] num, den, q;
    int e, k;
    bit sat;
    lim = m_neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    m = m_mant;
    e = (m_eneg ? -m_exp : m_exp) + m_drop - m_fcnt;
    if (m == 0) return 32'h0;
    if (e >= 0) begin
      sat = 0;
      for (int i = 0; i < e && !sat; i++) begin
        if (m > lim) sat = 1;
        else m = m * 10;
      end
      mag = (sat || m > (lim >> 16)) ? lim : (m << 16);
    end else begin
      k = (-e > 40) ? 40 : -e;
      den = 192'd1;
      for (int i = 0; i < k; i++) den = den * 10;
      num = {128'd0, m} << 17;
      q = num / den;
      if (|q[191:64]) mag = lim;
      else begin
        q64 = (q[63:0] >> 1) + q[0];
        mag = (q64 > lim) ? lim : q64;
      end
    end
    return m_neg ? -mag[31:0] : mag[31:0];
  endfunction

  function automatic void finish_number();
    if (m_field < 3) m_res[m_field] = (m_kind == KIND_V) ? fixed_value() : face_value();
  endfunction

  function automatic bit take_char(logic [7:0] c);
    bit dig, sgn, ex;
    int d;
    logic [63:0] t;
    dig = c >= CH_ZERO && c <= CH_NINE;
    sgn = c == CH_PLUS || c == CH_MINUS;
    ex  = c == CH_E || c == CH_EU;
    d   = dig ? c - CH_ZERO : 0;
    if (m_phase == PH_GAP) begin
      if (blank_char(c)) return 1;
      if (sgn) begin
        m_neg = (c == CH_MINUS); m_phase = PH_INT; return 1;
      end
    end
    if (m_kind == KIND_F) begin
      if (dig && m_dcnt < 31) begin
        t = m_mant * 10 + d;
        m_mant = (t > 64'h8000_0000) ? 64'h8000_0000 : t;
        m_dcnt++;
        m_phase = PH_INT;
        return 1;
      end
      return 0;
    end
    if (m_phase inside {PH_GAP, PH_INT, PH_FRAC}) begin
      if (dig) begin
        if (m_phase == PH_FRAC) begin
          if (m_mant == 0 && d == 0) m_fcnt = sat255(m_fcnt);
          else if (m_dcnt < 9) begin
            m_mant = m_mant * 10 + d; m_dcnt++; m_fcnt = sat255(m_fcnt);
          end
        end else begin
          if (!(m_mant == 0 && d == 0)) begin
            if (m_dcnt < 9) begin
              m_mant = m_mant * 10 + d; m_dcnt++;
            end else m_drop = sat255(m_drop);
          end
          m_phase = PH_INT;
        end
        return 1;
      end
      if (c == CH_DOT && m_phase != PH_FRAC) begin
        m_phase = PH_FRAC; return 1;
      end
      if (ex) begin
        m_phase = PH_ESTART; return 1;
      end
      return 0;
    end
    if (m_phase == PH_ESTART && sgn) begin
      m_eneg = (c == CH_MINUS); m_phase = PH_EDIG; return 1;
    end
    if ((m_phase == PH_ESTART || m_phase == PH_EDIG) && dig) begin
      m_exp = m_exp * 10 + d;
      if (m_exp > 255) m_exp = 255;
      m_phase = PH_EDIG;
      return 1;
    end
    return 0;
  endfunction

  function automatic bit parse_char(logic [7:0] c, output element_t el);
    el = '0;
    if (m_phase == PH_LINE) begin
      if (blank_char(c)) return 0;
      if (c == CH_V || c == CH_F) begin
        m_kind = (c == CH_V) ? KIND_V : KIND_F;
        m_field = 0; clear_number();
        m_res[0] = 0; m_res[1] = 0; m_res[2] = 0;
        m_phase = PH_GAP;
        return 0;
      end
      m_kind = KIND_NONE;
      if (c != CH_NUL) m_phase = PH_DISCARD;
      el.kind = ELEM_STOP;
      return 1;
    end
    if (m_phase == PH_DISCARD) begin
      if (c == CH_NL || c == CH_NUL) m_phase = PH_LINE;
      return 0;
    end
    if (c == CH_NL || c == CH_NUL) begin
      if (m_phase != PH_TAIL) finish_number();
      m_phase = PH_LINE;
      if (m_kind == KIND_V) begin
        el.kind = ELEM_VERTEX;
        el.cx = m_res[0]; el.cy = m_res[1]; el.cz = m_res[2];
        el.color = m_color;
      end else begin
        el.kind = ELEM_FACE;
        el.i1 = m_res[0]; el.i2 = m_res[1]; el.i3 = m_res[2];
      end
      return 1;
    end
    if (m_phase == PH_TAIL) return 0;
    if (m_phase != PH_GAP) begin
      if (take_char(c)) return 0;
      finish_number();
      m_field++;
      clear_number();
      if (m_field >= 3) begin
        m_phase = PH_TAIL; return 0;
      end
      m_phase = PH_GAP;
    end
    if (take_char(c)) return 0;
    m_phase = PH_TAIL;  // stuck field: rest of line ignored
    return 0;
  endfunction

  // input driver
  always @(negedge clk) begin
    if (push_gap > 0) begin
      push_gap--;
      in_push <= 1'b0;
    end else if (char_queue.size() > 0) begin
      in_push <= 1'b1;
      in_char_code <= char_queue[0];
    end else in_push <= 1'b0;
  end

  // result drain with random stalls
  always @(negedge clk) begin
    if (pop_gap > 0) begin
      pop_gap--;
      out_pop <= 1'b0;
    end else out_pop <= 1'b1;
  end

  always @(posedge clk) begin
    element_t el;
    if (rst_n && in_push && !in_full) begin
      if (parse_char(char_queue.pop_front(), el)) element_queue.push_back(el);
      push_gap = idle_len();
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %0d (0x%h) actual %0d (0x%h)", $time, name,
               $signed(exp_v), exp_v, $signed(act_v), act_v);
      fails++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    element_t el;
    if (rst_n && out_pop && !out_empty) begin
      if (element_queue.size() == 0) begin
        $display("%0t unexpected element: kind %0d", $time, out_element_kind);
        fails++;
      end else begin
        el = element_queue.pop_front();
        check_field("element_kind", 32'(el.kind), 32'(out_element_kind));
        check_field("coord_x", el.cx, out_coord_x);
        check_field("coord_y", el.cy, out_coord_y);
        check_field("coord_z", el.cz, out_coord_z);
        check_field("index_first", el.i1, out_index_first);
        check_field("index_second", el.i2, out_index_second);
        check_field("index_third", el.i3, out_index_third);
        check_field("vertex_color", 32'(el.color), 32'(out_vertex_color));
      end
      pop_gap = idle_len();
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) char_queue.push_back(s[i]);
  endtask

  task automatic push_digits(int n);
    for (int i = 0; i < n; i++) char_queue.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic push_blanks(int lo, int hi);
    int n;
    logic [7:0] opts[4];
    opts = '{CH_SPACE, CH_TAB, CH_CR, CH_SPACE};
    n = $urandom_range(lo, hi);
    for (int i = 0; i < n; i++) char_queue.push_back(opts[$urandom_range(0, 3)]);
  endtask

  task automatic push_sign();
    case ($urandom_range(0, 3))
      0: char_queue.push_back(CH_MINUS);
      1: char_queue.push_back(CH_PLUS);
      default: ;
    endcase
  endtask

  task automatic push_float();
    push_sign();
    push_digits(($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 5));
    if ($urandom_range(0, 2) != 0) begin
      char_queue.push_back(CH_DOT);
      if ($urandom_range(0, 4) == 0) push_text("000");
      push_digits(($urandom_range(0, 9) == 0) ? $urandom_range(8, 13) : $urandom_range(0, 5));
    end
    if ($urandom_range(0, 3) == 0) begin
      char_queue.push_back($urandom_range(0, 1) ? CH_E : CH_EU);
      push_sign();
      push_digits($urandom_range(0, 3));
    end
  endtask

  task automatic push_int();
    push_sign();
    push_digits(($urandom_range(0, 9) == 0) ? $urandom_range(10, 35) : $urandom_range(0, 6));
  endtask

  task automatic push_line_end();
    char_queue.push_back(($urandom_range(0, 9) == 0) ? CH_NUL : CH_NL);
  endtask

  task automatic push_element_line(bit vertex);
    int n;
    push_blanks(0, 2);
    char_queue.push_back(vertex ? CH_V : CH_F);
    if (vertex && $urandom_range(0, 9) == 0) char_queue.push_back("t");
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4) : 3;
    for (int i = 0; i < n; i++) begin
      push_blanks((i == 0 && $urandom_range(0, 5) != 0) ? 1 : 0, 2);
      if (vertex) push_float(); else push_int();
      if ($urandom_range(0, 14) == 0) char_queue.push_back(vertex ? "x" : "/");
      if ($urandom_range(0, 19) == 0) char_queue.push_back(8'($urandom_range(1, 255)));
    end
    if ($urandom_range(0, 5) == 0) push_blanks(1, 2);
    push_line_end();
  endtask

  task automatic push_random_line();
    int r;
    r = $urandom_range(0, 99);
    if (r < 42) push_element_line(1);
    else if (r < 74) push_element_line(0);
    else if (r < 80) begin
      push_blanks(0, 3);
      char_queue.push_back(CH_NL);
    end else if (r < 87) begin
      push_text("# c 1.0");
      push_line_end();
    end else if (r < 95) begin
      repeat ($urandom_range(1, 8)) char_queue.push_back(8'($urandom_range(0, 255)));
      char_queue.push_back(CH_NL);
    end else char_queue.push_back(CH_NUL);
  endtask

  task automatic wait_idle();
    while (char_queue.size() != 0 || element_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_color(logic [23:0] color);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_default_color <= color;
    do @(posedge clk); while (!cfg_ready);
    m_color = color;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int start;
    m_phase = PH_LINE; m_kind = KIND_NONE; m_field = 0; clear_number();
    m_res[0] = 0; m_res[1] = 0; m_res[2] = 0;
    m_color = 24'hFF_FFFF;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: blank line, vertex, face, unknown head, end of text at head
    push_text(" \t\nv 1 -2 .5\nf 9 -3\n#\n");
    char_queue.push_back(CH_NUL);
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1: write_color(24'h00_0000);
        2: write_color(24'hFF_FFFF);
        3: write_color(24'($urandom_range(0, 24'hFF_FFFF)));
        default: ;
      endcase
      no_idle = (phase == 2);
      start = char_queue.size();
      while (char_queue.size() - start < CHARS_PER_PHASE) push_random_line();
      char_queue.push_back(CH_NL);
      wait_idle();
    end
    if (fails == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
